// ===== hdl/oid_pkg.sv =====
// Package for the object identifier content decoder: result record, push record
// between the decode stage and the result queue, status codes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oid_pkg;

   // Octet layout.
   localparam logic [7:0] CONT_BIT   = 8'h80;
   localparam logic [7:0] GROUP_MASK = 8'h7f;
   localparam int unsigned GROUP_W   = 7;

   // The first sub-identifier is split on this base.
   localparam int unsigned SPLIT_BASE = 40;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // Arc numbering saturates at this value.
   localparam logic [7:0] ARC_NUM_MAX = 8'hff;

   // Result queue geometry.
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [31:0] arc_value;
      logic [7:0]  arc_number;
      logic [1:0]  status;
      logic        end_of_id;
   } oid_result_type;

   // What the decode stage hands to the result queue in one cycle.
   typedef struct packed {
      logic           busy;   // an octet is held in the decode stage
      logic [1:0]     count;  // results produced this cycle, 0 to 2
      oid_result_type res0;
      oid_result_type res1;
   } oid_push_type;

endpackage : oid_pkg

`default_nettype wire

// ===== hdl/oid_req_if.sv =====
// Input channel of the object identifier decoder: one content octet per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface oid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] content_byte;
   logic       final_octet;

   modport source (output valid, output content_byte, output final_octet, input ready);
   modport sink   (input valid, input content_byte, input final_octet, output ready);
endinterface : oid_req_if

`default_nettype wire

// ===== hdl/oid_rsp_if.sv =====
// Result channel of the object identifier decoder: one decoded arc per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface oid_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] arc_value;
   logic [7:0]  arc_number;
   logic [1:0]  status;
   logic        end_of_id;

   modport source (output valid, output arc_value, output arc_number, output status,
                   output end_of_id, input ready);
   modport sink   (input valid, input arc_value, input arc_number, input status,
                   input end_of_id, output ready);
endinterface : oid_rsp_if

`default_nettype wire

// ===== hdl/oid_content_decoder.sv =====
// Top level of the object identifier content decoder.
// Depends on oid_pkg, oid_req_if, oid_rsp_if, oid_decode and oid_rsp_queue.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes the content octets of an ASN.1 object identifier, one octet per
// transaction on the request channel, and returns the decoded arcs, one arc per
// transaction on the response channel. Octets are base-128 groups, most significant
// first, with bit 7 set on every octet but the last of a sub-identifier. The first
// sub-identifier gives two arcs (split on 40 below 80, otherwise 2 and the value
// minus 80); each later one gives one arc. Arcs are numbered from 0 within an
// identifier, saturating at 255, and the last arc carries end_of_id. Status reports
// an arc that overflowed ARC_WIDTH bits, or a final octet that still had its
// continuation bit set; the latter wins. An accepted octet is registered, decoded in
// the next cycle, and its arcs enter an eight-entry result queue. The response side
// delivers one arc per cycle while the consumer holds ready, so a stream sustains
// one octet per cycle except that the second arc of each first sub-identifier needs
// an extra output slot; the queue absorbs that and the request side stalls only
// when the queue could not take the arcs of the octets already in flight.
module oid_content_decoder
   import oid_pkg::*;
#(
   parameter int unsigned ARC_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   oid_req_if.sink    req_port,
   oid_rsp_if.source  rsp_port
);

   oid_push_type          push;
   logic [RSP_CNT_W-1:0]  fill;
   logic [RSP_CNT_W:0]    reserved;
   logic                  accept;

   // Room is reserved for two arcs of the octet in decode and two of a new one.
   assign reserved       = {1'b0, fill} + (push.busy ? (RSP_CNT_W+1)'(2) : '0)
                           + (RSP_CNT_W+1)'(2);
   assign req_port.ready = reserved <= (RSP_CNT_W+1)'(RSP_DEPTH);
   assign accept         = req_port.valid && req_port.ready;

   oid_decode #(
      .ARC_WIDTH (ARC_WIDTH)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .content_byte (req_port.content_byte),
      .final_octet  (req_port.final_octet),
      .push         (push)
   );

   oid_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fill     (fill),
      .rsp_port (rsp_port)
   );

endmodule : oid_content_decoder

`default_nettype wire

// ===== hdl/oid_decode.sv =====
// Decode stage: input octet register, base-128 accumulator and arc split logic.
// Depends on oid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oid_decode
   import oid_pkg::*;
#(
   parameter int unsigned ARC_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   content_byte,
   input  wire logic         final_octet,
   output oid_push_type      push
);

   localparam logic [ARC_WIDTH-1:0] SplitLo = ARC_WIDTH'(SPLIT_BASE);
   localparam logic [ARC_WIDTH-1:0] SplitHi = ARC_WIDTH'(2 * SPLIT_BASE);

   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff;
   logic                 final_ff;
   logic [ARC_WIDTH-1:0] acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   logic [7:0]           cnt_ff, cnt_in;
   logic                 first_ff, first_in;

   logic                 more, done, ovf_now, split_lo;
   logic [ARC_WIDTH-1:0] acc_new, second_arc;
   logic [1:0]           first_arc;
   logic [1:0]           status;
   logic [7:0]           cnt_p1, cnt_p2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= content_byte;
         final_ff <= final_octet;
      end
   end

   always_comb begin
      valid_in = accept;
      more     = (byte_ff & CONT_BIT) != 8'd0;
      done     = !more || final_ff;
      // Any set bit among the top group is lost by the shift.
      ovf_now  = ovf_ff || (acc_ff[ARC_WIDTH-1 -: GROUP_W] != '0);
      acc_new  = {acc_ff[ARC_WIDTH-GROUP_W-1:0], byte_ff[GROUP_W-1:0]};

      if (more && final_ff) begin
         status = STATUS_TRUNCATED;
      end else if (ovf_now) begin
         status = STATUS_OVERFLOW;
      end else begin
         status = STATUS_OK;
      end

      cnt_p1 = (cnt_ff == ARC_NUM_MAX) ? cnt_ff : cnt_ff + 8'd1;
      cnt_p2 = (cnt_p1 == ARC_NUM_MAX) ? cnt_p1 : cnt_p1 + 8'd1;

      // First sub-identifier: below 80 the value splits on 40, otherwise arc 0 is 2.
      split_lo = acc_new < SplitHi;
      if (split_lo) begin
         if (acc_new >= SplitLo) begin
            first_arc  = 2'd1;
            second_arc = acc_new - SplitLo;
         end else begin
            first_arc  = 2'd0;
            second_arc = acc_new;
         end
      end else begin
         first_arc  = 2'd2;
         second_arc = acc_new - SplitHi;
      end

      push.busy            = valid_ff;
      push.res0.arc_number = cnt_ff;
      push.res0.status     = status;
      push.res1.arc_number = cnt_p1;
      push.res1.status     = status;
      push.res1.arc_value  = 32'(second_arc);
      push.res1.end_of_id  = final_ff;
      if (first_ff) begin
         push.res0.arc_value = 32'(acc_new);
         push.res0.end_of_id = final_ff;
      end else begin
         push.res0.arc_value = 32'(first_arc);
         push.res0.end_of_id = 1'b0;
      end

      if (valid_ff && done) begin
         push.count = first_ff ? 2'd1 : 2'd2;
      end else begin
         push.count = 2'd0;
      end

      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      if (valid_ff) begin
         if (!done) begin
            acc_in = acc_new;
            ovf_in = ovf_now;
         end else begin
            acc_in = '0;
            ovf_in = 1'b0;
            if (final_ff) begin
               cnt_in   = '0;
               first_in = 1'b0;
            end else begin
               cnt_in   = first_ff ? cnt_p1 : cnt_p2;
               first_in = 1'b1;
            end
         end
      end
   end

   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.res0.end_of_id)
      else $error("first arc of a split sub-identifier marked as last");

   a_pair_same_status: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.res0.status == push.res1.status)
      else $error("split arcs carry different status");

   a_count_reset_after_end: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && final_ff |=> cnt_ff == 8'd0 && !first_ff)
      else $error("arc numbering not restarted after end of identifier");

endmodule : oid_decode

`default_nettype wire

// ===== hdl/oid_rsp_queue.sv =====
// Result queue: takes up to two arcs per cycle from the decode stage, hands one
// per transaction to the result channel. Depends on oid_pkg and oid_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module oid_rsp_queue
   import oid_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire oid_push_type   push,
   output logic [RSP_CNT_W-1:0] fill,
   oid_rsp_if.source           rsp_port
);

   oid_result_type          entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]    count_ff, count_in;
   logic [RSP_PTR_W-1:0]    wr_next;
   logic                    pop;
   oid_result_type          head;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   always_comb begin
      wr_next   = wr_ptr_ff + RSP_PTR_W'(1);
      pop       = rsp_port.valid && rsp_port.ready;
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
      head      = entry_ff[rd_ptr_ff];
      fill      = count_ff;
   end

   assign rsp_port.valid      = count_ff != '0;
   assign rsp_port.arc_value  = head.arc_value;
   assign rsp_port.arc_number = head.arc_number;
   assign rsp_port.status     = head.status;
   assign rsp_port.end_of_id  = head.end_of_id;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} + {{(RSP_CNT_W-1){1'b0}}, push.count} <= (RSP_CNT_W+1)'(RSP_DEPTH))
      else $error("result queue written past its depth");

   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - RSP_CNT_W'(1))
      else $error("queue count not reduced by a pop");

endmodule : oid_rsp_queue

`default_nettype wire

// ===== test/tb_oid_content_decoder.sv =====
// Self-checking testbench for oid_content_decoder: a short table of directed octets, then
// random identifiers, every arc checked against the typed table rows or an arc predictor in this file.
// Depends on oid_pkg, oid_req_if, oid_rsp_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_oid_content_decoder;
   import oid_pkg::*;

   localparam int unsigned ARC_WIDTH     = 32;
   localparam int unsigned RANDOM_OCTETS = 1450;
   localparam int unsigned LONG_ID_ARCS  = 270;   // enough to saturate arc numbers at 255
   localparam int unsigned STALL_MAX     = 17;
   localparam int unsigned IDLE_LIMIT    = 600;
   localparam int unsigned DRAIN_CYCLES  = 24;
   localparam int unsigned REPORT_MAX    = 40;

   // One row of the directed table. A row with n_typed of -1 has no typed result and is
   // checked against the predictor; otherwise n_typed arcs are taken from the row.
   typedef struct {
      logic [7:0]     octet;
      logic           last;
      int             n_typed;
      oid_result_type arc0;
      oid_result_type arc1;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // The clock inverts every half period of 6 ns.
   always #6 clock = ~clock;

   oid_req_if req_bus ();
   oid_rsp_if rsp_bus ();

   oid_content_decoder #(.ARC_WIDTH(ARC_WIDTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Predictor state: the partial sub-identifier, its overflow flag, the number of arcs
   // already produced in this identifier and whether the first sub-identifier was split.
   logic [ARC_WIDTH-1:0] acc_q         = '0;
   logic                 ovf_q         = 1'b0;
   logic [7:0]           arc_cnt_q     = '0;
   logic                 first_split_q = 1'b0;

   // Arcs that the block owes, oldest first.
   oid_result_type arcs_due[$];
   stim_row_type   stim_rows[$];

   int unsigned errors       = 0;
   int unsigned octets_sent  = 0;
   int unsigned ids_sent     = 0;
   int unsigned arcs_seen    = 0;
   int unsigned trunc_arcs   = 0;
   int unsigned ovf_arcs     = 0;
   int unsigned sat_arcs     = 0;
   int unsigned idle_cycles  = 0;

   // When set, the matching side of the handshake runs without any idle cycles.
   logic req_calm  = 1'b0;
   logic sink_calm = 1'b0;

   function automatic oid_result_type make_arc(input logic [63:0] value, input logic [7:0] num,
                                               input logic [1:0] st, input logic eoi);
      oid_result_type r;
      r.arc_value  = value[31:0];
      r.arc_number = num;
      r.status     = st;
      r.end_of_id  = eoi;
      return r;
   endfunction

   function automatic logic [7:0] next_arc_num(input logic [7:0] num);
      return (num == ARC_NUM_MAX) ? num : num + 8'd1;
   endfunction

   // Decodes one accepted octet and returns the arcs it completes, if any.
   task automatic decode_octet(input logic [7:0] octet, input logic last, output int n,
                               output oid_result_type r0, output oid_result_type r1);
      logic                 more;
      logic [1:0]           st;
      logic [ARC_WIDTH-1:0] v;
      more = |(octet & CONT_BIT);
      n    = 0;
      r0   = '0;
      r1   = '0;
      // A significant bit about to be shifted out marks the sub-identifier as overflowed.
      if (acc_q[ARC_WIDTH-1 -: GROUP_W] != '0)
         ovf_q = 1'b1;
      acc_q = {acc_q[ARC_WIDTH-GROUP_W-1:0], octet[6:0]};
      if (!more || last) begin
         v  = acc_q;
         // A final octet that still asks for more wins over an overflow.
         st = more ? STATUS_TRUNCATED : (ovf_q ? STATUS_OVERFLOW : STATUS_OK);
         if (!first_split_q) begin
            if (v < 2 * SPLIT_BASE)
               r0 = make_arc(v / SPLIT_BASE, arc_cnt_q, st, 1'b0);
            else
               r0 = make_arc(2, arc_cnt_q, st, 1'b0);
            arc_cnt_q = next_arc_num(arc_cnt_q);
            if (v < 2 * SPLIT_BASE)
               r1 = make_arc(v % SPLIT_BASE, arc_cnt_q, st, last);
            else
               r1 = make_arc(v - 2 * SPLIT_BASE, arc_cnt_q, st, last);
            arc_cnt_q     = next_arc_num(arc_cnt_q);
            first_split_q = 1'b1;
            n             = 2;
         end else begin
            r0        = make_arc(v, arc_cnt_q, st, last);
            arc_cnt_q = next_arc_num(arc_cnt_q);
            n         = 1;
         end
         acc_q = '0;
         ovf_q = 1'b0;
         if (last) begin
            arc_cnt_q     = '0;
            first_split_q = 1'b0;
         end
      end
   endtask

   task automatic push_arcs(input int n, input oid_result_type r0, input oid_result_type r1);
      oid_result_type r;
      for (int k = 0; k < n; k++) begin
         r = (k == 0) ? r0 : r1;
         arcs_due.push_back(r);
         if (r.status == STATUS_TRUNCATED)
            trunc_arcs++;
         if (r.status == STATUS_OVERFLOW)
            ovf_arcs++;
         if (r.arc_number == ARC_NUM_MAX)
            sat_arcs++;
      end
   endtask

   // Offers one octet after a random gap and returns at the edge where it is taken.
   // The valid line is driven low at the falling edges of the gap and high at the last one.
   task automatic send_octet(input logic [7:0] octet, input logic last);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, STALL_MAX);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.content_byte <= octet;
      req_bus.final_octet  <= last;
      do @(posedge clock); while (!req_bus.ready);
      octets_sent++;
   endtask

   task automatic feed_octet(input logic [7:0] octet, input logic last);
      int             n;
      oid_result_type r0;
      oid_result_type r1;
      send_octet(octet, last);
      decode_octet(octet, last, n, r0, r1);
      push_arcs(n, r0, r1);
   endtask

   task automatic add_row(input logic [7:0] octet, input logic last, input int n_typed,
                          input oid_result_type arc0, input oid_result_type arc1);
      stim_row_type row;
      row.octet   = octet;
      row.last    = last;
      row.n_typed = n_typed;
      row.arc0    = arc0;
      row.arc1    = arc1;
      stim_rows.push_back(row);
   endtask

   // Draws a sub-identifier value. Most are short, some fill 32 bits and a few are wider
   // than the arc so that the overflow flag gets exercised.
   function automatic logic [41:0] pick_sub_id(input logic small_only);
      logic [41:0] v;
      if (small_only) begin
         v = 42'($urandom_range(0, 127));
      end else begin
         case ($urandom_range(0, 9)) inside
            [0:3]:   v = 42'($urandom_range(0, 127));
            [4:5]:   v = 42'($urandom_range(128, 16383));
            [6:7]:   v = {10'd0, $urandom};
            8:       v = {10'd0, $urandom | 32'hFE00_0000};
            default: v = {10'($urandom_range(1, 1023)), $urandom};
         endcase
      end
      return v;
   endfunction

   // Sends one sub-identifier as base-128 groups, most significant first. Now and then it
   // is led by zero-valued padding octets. With cut set the last octet keeps bit 7.
   task automatic feed_sub_id(input logic [41:0] value, input logic last, input logic cut);
      int         ng;
      int         pad;
      logic [7:0] octet;
      ng = 1;
      for (int k = 1; k < 6; k++)
         if ((value >> (7 * k)) != 0)
            ng = k + 1;
      pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
      repeat (pad)
         feed_octet(CONT_BIT, 1'b0);
      for (int g = ng - 1; g >= 0; g--) begin
         octet = {(g != 0) || cut, value[7 * g +: 7]};
         feed_octet(octet, last && (g == 0));
      end
   endtask

   task automatic feed_identifier(input int unsigned n_sub, input logic cut,
                                  input logic small_only);
      for (int unsigned i = 0; i < n_sub; i++)
         feed_sub_id(pick_sub_id(small_only), i == n_sub - 1, cut && (i == n_sub - 1));
   endtask

   // Random octets with random end marks; the run may or may not close the identifier.
   task automatic feed_noise();
      int unsigned n;
      logic        last;
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++) begin
         if (i == n - 1)
            last = 1'($urandom_range(0, 1));
         else
            last = ($urandom_range(0, 3) == 0);
         feed_octet(8'($urandom_range(0, 255)), last);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= REPORT_MAX)
         $display("mismatch on %s at %0t ns, arc transaction %0d: got 0x%0h, expected 0x%0h",
                  what, $time, arcs_seen, got, want);
   endtask

   // Every arc transaction is compared with the oldest arc still owed. Outputs are
   // sampled at the rising edge, where the values before the edge are seen.
   always @(posedge clock) begin
      oid_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         arcs_seen++;
         if (arcs_due.size() == 0) begin
            report_mismatch("arc with nothing owed", rsp_bus.arc_value, 32'd0);
         end else begin
            want = arcs_due.pop_front();
            if (rsp_bus.arc_value !== want.arc_value)
               report_mismatch("arc_value", rsp_bus.arc_value, want.arc_value);
            if (rsp_bus.arc_number !== want.arc_number)
               report_mismatch("arc_number", 32'(rsp_bus.arc_number), 32'(want.arc_number));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
            if (rsp_bus.end_of_id !== want.end_of_id)
               report_mismatch("end_of_id", 32'(rsp_bus.end_of_id), 32'(want.end_of_id));
         end
      end
   end

   // The watchdog counts cycles without any transaction on either channel. A correct
   // block never goes that long, since the random stalls on either side are far shorter.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d arcs still owed",
                  idle_cycles, arcs_due.size());
         $display("tb_oid_content_decoder: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: ready drops for a random number of cycles before each arc, with calm
   // stretches where it stays high throughout.
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 29) == 0)
            sink_calm = !sink_calm;
         stall = sink_calm ? 0 : $urandom_range(0, STALL_MAX);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      int             n;
      oid_result_type r0;
      oid_result_type r1;
      oid_result_type none;
      stim_row_type   row;

      req_bus.valid        = 1'b0;
      req_bus.content_byte = '0;
      req_bus.final_octet  = 1'b0;
      none                 = '0;

      // Single-octet identifiers at the split boundaries: zero, the last value split by 40,
      // the first value that maps to arc 2, and the largest single group.
      add_row(8'h00, 1'b1, 2, make_arc(0, 0, STATUS_OK, 1'b0), make_arc(0, 1, STATUS_OK, 1'b1));
      add_row(8'h4f, 1'b1, 2, make_arc(1, 0, STATUS_OK, 1'b0), make_arc(39, 1, STATUS_OK, 1'b1));
      add_row(8'h50, 1'b1, 2, make_arc(2, 0, STATUS_OK, 1'b0), make_arc(0, 1, STATUS_OK, 1'b1));
      add_row(8'h7f, 1'b1, 2, make_arc(2, 0, STATUS_OK, 1'b0), make_arc(47, 1, STATUS_OK, 1'b1));
      // A three-arc identifier whose last arc spans two octets.
      add_row(8'h2a, 1'b0, 2, make_arc(1, 0, STATUS_OK, 1'b0), make_arc(2, 1, STATUS_OK, 1'b0));
      add_row(8'h86, 1'b0, -1, none, none);
      add_row(8'h48, 1'b1, -1, none, none);
      // A final octet that still has its continuation bit set.
      add_row(8'h81, 1'b1, 2, make_arc(0, 0, STATUS_TRUNCATED, 1'b0),
              make_arc(1, 1, STATUS_TRUNCATED, 1'b1));
      // A leading padding octet is accepted without a flag.
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h01, 1'b1, 2, make_arc(0, 0, STATUS_OK, 1'b0), make_arc(1, 1, STATUS_OK, 1'b1));
      // The largest value that fits 32 bits, with no overflow.
      add_row(8'h8f, 1'b0, 0, none, none);
      add_row(8'hff, 1'b0, 0, none, none);
      add_row(8'hff, 1'b0, 0, none, none);
      add_row(8'hff, 1'b0, 0, none, none);
      add_row(8'h7f, 1'b1, 2, make_arc(2, 0, STATUS_OK, 1'b0),
              make_arc(32'hFFFF_FFAF, 1, STATUS_OK, 1'b1));
      // Two to the 32nd: a set bit is shifted out and the value wraps to zero.
      add_row(8'h90, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h00, 1'b1, 2, make_arc(0, 0, STATUS_OVERFLOW, 1'b0),
              make_arc(0, 1, STATUS_OVERFLOW, 1'b1));
      // The same overflow closed by a truncated octet: truncation takes precedence.
      add_row(8'h90, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h80, 1'b0, 0, none, none);
      add_row(8'h80, 1'b1, 2, make_arc(0, 0, STATUS_TRUNCATED, 1'b0),
              make_arc(0, 1, STATUS_TRUNCATED, 1'b1));

      // Reset is released at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The predictor runs on every row so that its state stays in step.
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         send_octet(row.octet, row.last);
         decode_octet(row.octet, row.last, n, r0, r1);
         if (row.n_typed >= 0)
            push_arcs(row.n_typed, row.arc0, row.arc1);
         else
            push_arcs(n, r0, r1);
      end

      // Random part. Most identifiers are well formed with random content; the rest are
      // truncated ones and runs of raw octets. One long identifier saturates arc numbers.
      while (octets_sent < stim_rows.size() + RANDOM_OCTETS) begin
         req_calm = ($urandom_range(0, 4) == 0);
         ids_sent++;
         if (ids_sent == 12) begin
            feed_identifier(LONG_ID_ARCS, 1'b0, 1'b1);
         end else begin
            case ($urandom_range(0, 19)) inside
               [0:1]:   feed_noise();
               [2:3]:   feed_identifier($urandom_range(1, 6), 1'b1, 1'b0);
               default: feed_identifier($urandom_range(1, 6), 1'b0, 1'b0);
            endcase
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Wait for every owed arc, then keep the clock running to catch a stray transaction.
      // A block that never delivers is caught by the watchdog.
      while (arcs_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d octets in about %0d identifiers, %0d arcs checked",
               octets_sent, ids_sent + 1, arcs_seen);
      $display("of those arcs %0d truncated, %0d overflowed, %0d at the saturated number",
               trunc_arcs, ovf_arcs, sat_arcs);
      if (errors == 0)
         $display("tb_oid_content_decoder: done, clean");
      else
         $display("tb_oid_content_decoder: done, errors");
      $finish;
   end

endmodule : tb_oid_content_decoder
